// File: design/energy_efficient_cpu_select_top_defines.svh
// Assertion macros used by the checker module.
`ifndef ENERGY_EFFICIENT_CPU_SELECT_TOP_DEFINES_SVH
`define ENERGY_EFFICIENT_CPU_SELECT_TOP_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define EES_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define EES_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/ees_pkg.sv
package ees_pkg;

    localparam int CLUSTERS_DEF = 4;
    localparam int STATES_DEF   = 32;
    localparam int CPUS_DEF     = 32;

    localparam int        CPU_W  = 6;
    localparam logic [5:0] NO_CPU = 6'h3F;

    localparam int DIV_LONG  = 52;
    localparam int DIV_SHORT = 26;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [1:0]  cluster;
        logic [4:0]  slot_or_cpu;
        logic [15:0] cap_or_nxt_cap;
        logic [15:0] cap_s_or_util_uss;
        logic [15:0] power_or_util_sse;
        logic [15:0] power_s_or_weight;
        logic [15:0] stat_pwr;
        logic        last_state_or_sse;
        logic        cpu_idle;
        logic        last_candidate;
    } t_item;

    typedef struct packed {
        logic        found;
        logic [4:0]  selected_cpu;
        logic [31:0] best_efficiency;
        logic        idle_chosen;
    } t_result;

    typedef struct packed {
        logic [15:0] cap;
        logic [15:0] cap_s;
        logic [15:0] pow;
        logic [15:0] pow_s;
        logic [15:0] stat;
    } t_entry;

    typedef struct packed {
        logic start;
        logic long_op;
    } t_div_ctl;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_CMP, ST_DIV1, ST_WAIT1, ST_ACC1, ST_DIV2, ST_WAIT2,
        ST_ACC2, ST_MUL3, ST_DIV3, ST_WAIT3, ST_UPD
    } t_state;

endpackage

// File: design/ees_tab.sv
module ees_tab
    import ees_pkg::*;
#(
    parameter int CLUSTERS = CLUSTERS_DEF,
    parameter int STATES   = STATES_DEF,
    localparam int DEPTH   = CLUSTERS * STATES,
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/ees_div.sv
module ees_div
    import ees_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_div_ctl            i_ctl,
    input  logic [DIV_LONG-1:0] i_dividend,
    input  logic [31:0]         i_divisor,
    output logic [31:0]         o_quot,
    output logic                o_done
);

    logic [DIV_LONG-1:0] r_num;
    logic [32:0]         r_rem;
    logic [31:0]         r_div;
    logic [31:0]         r_quot;
    logic [5:0]          r_cnt;
    logic                r_run;
    logic                r_done;
    logic [32:0]         trial;
    logic                ge;
    logic [32:0]         n_rem;

    // One quotient bit per cycle, restoring form.
    always_comb begin
        trial = {r_rem[31:0], r_num[DIV_LONG-1]};
        ge    = (trial >= {1'b0, r_div});
        n_rem = ge ? (trial - {1'b0, r_div}) : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_run <= 1'b1;
            end else if (r_run && r_cnt == 6'd1) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_num  <= i_dividend;
            r_div  <= i_divisor;
            r_rem  <= '0;
            r_quot <= '0;
            r_cnt  <= i_ctl.long_op ? 6'(DIV_LONG) : 6'(DIV_SHORT);
        end else if (r_run) begin
            r_num  <= {r_num[DIV_LONG-2:0], 1'b0};
            r_rem  <= n_rem;
            r_quot <= {r_quot[30:0], ge};
            r_cnt  <= r_cnt - 6'd1;
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

// File: design/energy_efficient_cpu_select_top.sv
// Energy-efficient cpu selection.
// Items arrive on i_item and are taken at a clock edge where i_start is high and o_busy
// is low. A load item (mode 0) writes one state of a cluster's energy table in that
// single cycle and never raises o_busy. An evaluate item (mode 1) raises o_busy while
// the candidate is scored; when last_candidate is set, the decision leaves on o_result
// with o_result_valid high for exactly one cycle as o_busy falls. The receiver cannot
// stall, so the result beat is simply presented once.
// An evaluate beat reads and compares one table state at a time (one memory read and
// one compare per state searched), then runs three bit-serial divisions of 26, 26 and
// 52 quotient bits on one shared divider before the update state. An empty table or
// an invalid cluster goes straight from idle to the update state, and a zero divisor
// or energy ends the scoring early. The next beat is taken at the earliest in the cycle
// that presents the result; the divider dominates the scoring time.
// The idle preference register is written on its own valid/ready channel, which is
// always ready; it should only change while the block is idle.
// Reset clears the valid-state counts, the running bests and the idle preference. The
// energy tables are not cleared; states must be loaded before they are used.
module energy_efficient_cpu_select_top
    import ees_pkg::*;
#(
    parameter int CLUSTERS = CLUSTERS_DEF,
    parameter int STATES   = STATES_DEF,
    parameter int CPUS     = CPUS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    output logic    o_busy,
    input  t_item   i_item,
    output t_result o_result,
    output logic    o_result_valid,
    input  logic    i_cfg_valid,
    output logic    o_cfg_ready,
    input  logic    i_cfg_data
);

    localparam int DEPTH = CLUSTERS * STATES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = (STATES > 1) ? $clog2(STATES) : 1;
    localparam int NW    = $clog2(STATES + 1);
    localparam int CW    = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;

    t_state r_state, n_state;

    logic            r_favour_idle;
    logic [NW-1:0]   r_nvalid [CLUSTERS];
    t_item           r_item;
    logic [SW-1:0]   r_idx;
    t_entry          r_ent;
    logic [31:0]     r_prod;
    logic [31:0]     r_energy;
    logic [31:0]     r_eff;
    logic [31:0]     r_busy_eff, r_idle_eff;
    logic [CPU_W-1:0] r_busy_cpu, r_idle_sel;
    t_result         r_res;
    logic            r_res_valid;

    logic          accept;
    logic          cl_ok;
    logic [CW-1:0] cl_idx;
    logic [NW-1:0] nvalid;
    logic          empty_eval;

    t_entry        tab_rdata;
    logic          tab_we;
    logic [AW-1:0] tab_waddr;
    logic [AW-1:0] tab_raddr;
    t_entry        tab_wdata;

    t_div_ctl            div_ctl;
    logic [DIV_LONG-1:0] div_dividend;
    logic [31:0]         div_divisor;
    logic [31:0]         div_quot;
    logic                div_done;

    logic          hit;
    logic [15:0]   mul_a;
    logic [31:0]   mul_b;
    logic [31:0]   mul_p;
    logic [31:0]   stat_sh;

    assign accept = i_start && !o_busy;
    assign cl_ok  = (32'(i_item.cluster) < CLUSTERS);
    assign cl_idx = CW'(i_item.cluster);
    assign nvalid = cl_ok ? r_nvalid[cl_idx] : '0;
    assign empty_eval = !cl_ok || (nvalid == '0);

    // Table write on a load beat; out-of-range loads are dropped.
    assign tab_we    = accept && (i_item.mode == MODE_LOAD) && cl_ok
                       && (32'(i_item.slot_or_cpu) < STATES);
    assign tab_waddr = AW'(32'(i_item.cluster) * STATES + 32'(i_item.slot_or_cpu));
    assign tab_wdata = '{cap:   i_item.cap_or_nxt_cap,
                         cap_s: i_item.cap_s_or_util_uss,
                         pow:   i_item.power_or_util_sse,
                         pow_s: i_item.power_s_or_weight,
                         stat:  i_item.stat_pwr};
    assign tab_raddr = AW'(32'(r_item.cluster) * STATES + 32'(r_idx));

    ees_tab #(.CLUSTERS(CLUSTERS), .STATES(STATES)) u_tab (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_raddr (tab_raddr),
        .o_rdata (tab_rdata)
    );

    // The search stops at the first state that reaches the next capacity, or at the last.
    assign hit = (tab_rdata.cap >= r_item.cap_or_nxt_cap)
                 || ((NW'(r_idx) + NW'(1)) == r_nvalid[CW'(r_item.cluster)]);

    // Divider operands: the two utilisation quotients are 26-bit dividends placed at
    // the top of the shift register, the efficiency numerator takes the full width.
    always_comb begin
        div_ctl      = '{start: 1'b0, long_op: 1'b0};
        div_dividend = '0;
        div_divisor  = '0;
        unique case (r_state)
            ST_DIV1: begin
                div_ctl.start = (r_ent.cap_s != '0);
                div_dividend  = {r_item.power_or_util_sse, 10'b0, 26'b0};
                div_divisor   = {16'b0, r_ent.cap_s};
            end
            ST_DIV2: begin
                div_ctl.start = (r_ent.cap != '0);
                div_dividend  = {r_item.cap_s_or_util_uss, 10'b0, 26'b0};
                div_divisor   = {16'b0, r_ent.cap};
            end
            ST_DIV3: begin
                div_ctl       = '{start: 1'b1, long_op: 1'b1};
                div_dividend  = {r_prod, 20'b0};
                div_divisor   = r_energy;
            end
            default: begin
            end
        endcase
    end

    ees_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quot     (div_quot),
        .o_done     (div_done)
    );

    // One shared multiplier, only the low 32 bits are kept.
    always_comb begin
        unique case (r_state)
            ST_ACC1: begin
                mul_a = r_ent.pow_s;
                mul_b = div_quot;
            end
            ST_ACC2: begin
                mul_a = r_ent.pow;
                mul_b = div_quot;
            end
            ST_MUL3: begin
                mul_a = r_item.power_s_or_weight;
                mul_b = {16'b0, r_item.last_state_or_sse ? r_ent.cap_s : r_ent.cap};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p   = 32'(mul_a * mul_b);
        stat_sh = {6'b0, r_ent.stat, 10'b0};
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_item.mode == MODE_EVAL) begin
                    n_state = empty_eval ? ST_UPD : ST_RD;
                end
            end
            ST_RD:    n_state = ST_CMP;
            ST_CMP:   n_state = hit ? ST_DIV1 : ST_RD;
            ST_DIV1:  n_state = (r_ent.cap_s == '0) ? ST_UPD : ST_WAIT1;
            ST_WAIT1: n_state = div_done ? ST_ACC1 : ST_WAIT1;
            ST_ACC1:  n_state = ST_DIV2;
            ST_DIV2:  n_state = (r_ent.cap == '0) ? ST_UPD : ST_WAIT2;
            ST_WAIT2: n_state = div_done ? ST_ACC2 : ST_WAIT2;
            ST_ACC2:  n_state = ST_MUL3;
            ST_MUL3:  n_state = (r_energy == '0) ? ST_UPD : ST_DIV3;
            ST_DIV3:  n_state = ST_WAIT3;
            ST_WAIT3: n_state = div_done ? ST_UPD : ST_WAIT3;
            ST_UPD:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_busy      = (r_state != ST_IDLE);
        o_cfg_ready = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_item <= i_item;
                    r_idx  <= '0;
                    r_eff  <= '0;
                end
            end
            ST_CMP: begin
                if (hit) begin
                    r_ent <= tab_rdata;
                end else begin
                    r_idx <= r_idx + SW'(1);
                end
            end
            ST_DIV1, ST_DIV2: r_eff <= '0;
            ST_ACC1: r_energy <= 32'(33'd1 + 33'(mul_p) + 33'(stat_sh));
            ST_ACC2: r_energy <= 32'(34'(r_energy) + 34'd1 + 34'(mul_p) + 34'(stat_sh));
            ST_MUL3: begin
                r_prod <= mul_p;
                r_eff  <= '0;
            end
            ST_WAIT3: begin
                if (div_done) begin
                    r_eff <= div_quot;
                end
            end
            default: begin
            end
        endcase
    end

    // Running bests, decision and valid-state counts.
    logic             upd_idle;
    logic             upd_ok;
    logic [31:0]      nb_eff, ni_eff;
    logic [CPU_W-1:0] nb_cpu, ni_cpu;
    logic [31:0]      bias_eff;
    logic             idle_wins;
    t_result          dec;

    always_comb begin
        upd_ok   = (32'(r_item.slot_or_cpu) < CPUS);
        upd_idle = r_favour_idle && r_item.cpu_idle;
        nb_eff   = r_busy_eff;
        nb_cpu   = r_busy_cpu;
        ni_eff   = r_idle_eff;
        ni_cpu   = r_idle_sel;
        if (upd_ok) begin
            if (upd_idle) begin
                if (r_eff > r_idle_eff) begin
                    ni_eff = r_eff;
                    ni_cpu = CPU_W'(r_item.slot_or_cpu);
                end
            end else if (r_eff > r_busy_eff) begin
                nb_eff = r_eff;
                nb_cpu = CPU_W'(r_item.slot_or_cpu);
            end
        end
        bias_eff  = ni_eff + {2'b0, ni_eff[31:2]};
        idle_wins = r_favour_idle && (ni_cpu != NO_CPU) && (bias_eff >= nb_eff);
        if (idle_wins) begin
            dec = '{found: 1'b1, selected_cpu: ni_cpu[4:0],
                    best_efficiency: bias_eff, idle_chosen: 1'b1};
        end else if (nb_cpu != NO_CPU) begin
            dec = '{found: 1'b1, selected_cpu: nb_cpu[4:0],
                    best_efficiency: nb_eff, idle_chosen: 1'b0};
        end else begin
            dec = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_favour_idle <= 1'b0;
            r_busy_eff    <= '0;
            r_idle_eff    <= '0;
            r_busy_cpu    <= NO_CPU;
            r_idle_sel    <= NO_CPU;
            r_res_valid   <= 1'b0;
            for (int c = 0; c < CLUSTERS; c++) begin
                r_nvalid[c] <= '0;
            end
        end else begin
            r_res_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_favour_idle <= i_cfg_data;
            end
            if (tab_we && i_item.last_state_or_sse) begin
                r_nvalid[cl_idx] <= NW'(32'(i_item.slot_or_cpu) + 1);
            end
            if (r_state == ST_UPD) begin
                if (r_item.last_candidate) begin
                    r_res_valid <= 1'b1;
                    r_busy_eff  <= '0;
                    r_idle_eff  <= '0;
                    r_busy_cpu  <= NO_CPU;
                    r_idle_sel  <= NO_CPU;
                end else begin
                    r_busy_eff  <= nb_eff;
                    r_idle_eff  <= ni_eff;
                    r_busy_cpu  <= nb_cpu;
                    r_idle_sel  <= ni_cpu;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPD && r_item.last_candidate) begin
            r_res <= dec;
        end
    end

    assign o_result       = r_res;
    assign o_result_valid = r_res_valid;

endmodule

// File: design/ees_checker.sv
`include "energy_efficient_cpu_select_top_defines.svh"

module ees_checker
    import ees_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_start,
    input logic    o_busy,
    input t_item   i_item,
    input t_result o_result,
    input logic    o_result_valid
);

    `EES_ASSERT(a_res_after_busy, i_clk, i_rst_n, o_result_valid |-> $past(o_busy), "result without preceding work")
    `EES_ASSERT(a_res_single, i_clk, i_rst_n, o_result_valid |=> !o_result_valid, "result strobe longer than one cycle")
    `EES_ASSERT(a_eval_busy, i_clk, i_rst_n, (i_start && !o_busy && i_item.mode == MODE_EVAL) |=> o_busy, "evaluate beat did not start work")
    `EES_ASSERT(a_not_found_zero, i_clk, i_rst_n, (o_result_valid && !o_result.found) |-> (o_result.best_efficiency == '0 && !o_result.idle_chosen), "empty decision carries data")
    `EES_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> (!o_result_valid && !o_busy), "activity right after reset")

endmodule

bind energy_efficient_cpu_select_top ees_checker u_ees_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .i_item         (i_item),
    .o_result       (o_result),
    .o_result_valid (o_result_valid)
);
